// File: sv/sef_pkg.sv
package sef_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam int COL_W  = $clog2(MAX_WIDTH);   // column position bits
  localparam int ROW_W  = $clog2(MAX_HEIGHT);  // row position bits
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 11;
  localparam int WREG_W = 12;                  // image_width register
  localparam int HREG_W = 13;                  // image_height register
  localparam int CFG_DATA_W = HREG_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
  localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);

  // first row / column that has a full 3x3 neighborhood
  localparam int FIRST_FULL = 2;

  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_col;
    logic             wr_en;
    logic [COL_W-1:0] wr_col;
  } lw_ctrl_t;

endpackage

// File: sv/sobel_edge_filter_3x3_unit.sv
// Pipeline: stage 1, stage 2 and output registers. Throughput: one pixel per
// clock unless the output is back-pressured; the line-store RAM is read at
// accept and written as stage 1 advances, with same-column forwarding, so no
// bubbles occur. Border pixels produce no result beat.
// Reset: async active low; position, window and config go to reset values
// (640 x 480); the line-store RAM is not cleared and needs no clearing pass.
module sobel_edge_filter_3x3_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sef_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sef_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sef_pkg::PIX_W-1:0]         s_axis_tdata,  // [7:0] pixel_value
  input  logic                              s_axis_tuser,  // start_of_frame
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] centre_row, [22:12] centre_col, [33:23] gradient_x,
  // [44:34] gradient_y, [52:45] magnitude_x, [60:53] magnitude_y,
  // [68:61] combined, [71:69] zero
  output logic [sef_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int CW = sef_pkg::COL_W;
  localparam int RW = sef_pkg::ROW_W;
  localparam int PW = sef_pkg::PIX_W;
  localparam int GW = sef_pkg::GRAD_W;

  // used (saturated) image size
  logic [CW:0]  width_q;
  logic [RW:0]  height_q;
  logic [sef_pkg::WREG_W-1:0] w_raw;
  logic [sef_pkg::HREG_W-1:0] h_raw;

  always_comb begin
    w_raw = cfg_data_i[sef_pkg::WREG_W-1:0];
    h_raw = cfg_data_i[sef_pkg::HREG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= (CW+1)'(sef_pkg::WIDTH_RESET);
      height_q <= (RW+1)'(sef_pkg::HEIGHT_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sef_pkg::CFG_IDX_WIDTH: begin
          if (w_raw < sef_pkg::WREG_W'(sef_pkg::MIN_DIM)) begin
            width_q <= (CW+1)'(sef_pkg::MIN_DIM);
          end else if (w_raw > sef_pkg::WREG_W'(sef_pkg::MAX_WIDTH)) begin
            width_q <= (CW+1)'(sef_pkg::MAX_WIDTH);
          end else begin
            width_q <= (CW+1)'(w_raw);
          end
        end
        sef_pkg::CFG_IDX_HEIGHT: begin
          if (h_raw < sef_pkg::HREG_W'(sef_pkg::MIN_DIM)) begin
            height_q <= (RW+1)'(sef_pkg::MIN_DIM);
          end else if (h_raw > sef_pkg::HREG_W'(sef_pkg::MAX_HEIGHT)) begin
            height_q <= (RW+1)'(sef_pkg::MAX_HEIGHT);
          end else begin
            height_q <= (RW+1)'(h_raw);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- handshake / stage control
  logic s1_valid_q, s1_emit_q, s2_valid_q, out_valid_q;
  logic out_ready, s2_ready, s2_go, s1_go, in_go;

  always_comb begin
    out_ready     = !out_valid_q || m_axis_tready;
    s2_ready      = !s2_valid_q || out_ready;
    s2_go         = s2_valid_q && out_ready;
    s1_go         = s1_valid_q && (!s1_emit_q || s2_ready);
    s_axis_tready = !s1_valid_q || s1_go;
    in_go         = s_axis_tvalid && s_axis_tready;
  end

  // ---------------- position of the incoming pixel
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   c0, c1, cn;
  logic [RW:0]   r0, r1, rn;
  logic          emit;

  always_comb begin
    c0 = s_axis_tuser ? '0 : {1'b0, col_q};
    r0 = s_axis_tuser ? '0 : {1'b0, row_q};
    if (c0 >= width_q) begin
      c1 = '0;
      r1 = r0 + (RW+1)'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    if (r1 >= height_q) r1 = '0;
    emit = (r1 >= (RW+1)'(sef_pkg::FIRST_FULL)) && (c1 >= (CW+1)'(sef_pkg::FIRST_FULL));
    cn = c1 + (CW+1)'(1);
    rn = r1;
    if (cn >= width_q) begin
      cn = '0;
      rn = r1 + (RW+1)'(1);
      if (rn >= height_q) rn = '0;
    end
    col_d = cn[CW-1:0];
    row_d = rn[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_go) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage 1: line-store data back, gradients
  logic [PW-1:0] s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic [CW-1:0] s1_ccol_q;
  logic [RW-1:0] s1_crow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else if (in_go) begin
      s1_valid_q <= 1'b1;
      s1_emit_q  <= emit;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      s1_pix_q  <= s_axis_tdata;
      s1_col_q  <= c1[CW-1:0];
      s1_ccol_q <= c1[CW-1:0] - CW'(1);
      s1_crow_q <= r1[RW-1:0] - RW'(1);
    end
  end

  sef_pkg::lw_ctrl_t lw_ctrl;
  logic signed [GW-1:0] grad_x, grad_y;

  always_comb begin
    lw_ctrl.rd_en  = in_go;
    lw_ctrl.rd_col = c1[CW-1:0];
    lw_ctrl.wr_en  = s1_go;
    lw_ctrl.wr_col = s1_col_q;
  end

  sef_line_window u_line_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lw_ctrl),
    .pixel_i  (s1_pix_q),
    .grad_x_o (grad_x),
    .grad_y_o (grad_y)
  );

  // ---------------- stage 2: magnitudes
  logic signed [GW-1:0] s2_gx_q, s2_gy_q;
  logic [CW-1:0]        s2_col_q;
  logic [RW-1:0]        s2_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_go && s1_emit_q) begin
      s2_valid_q <= 1'b1;
    end else if (s2_go) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit_q) begin
      s2_gx_q  <= grad_x;
      s2_gy_q  <= grad_y;
      s2_col_q <= s1_ccol_q;
      s2_row_q <= s1_crow_q;
    end
  end

  logic [GW-1:0] abs_x, abs_y;
  logic [PW-1:0] mag_x, mag_y, comb;
  logic [PW:0]   mag_sum;

  always_comb begin
    abs_x = s2_gx_q[GW-1] ? GW'(-s2_gx_q) : GW'(s2_gx_q);
    abs_y = s2_gy_q[GW-1] ? GW'(-s2_gy_q) : GW'(s2_gy_q);
    mag_x = (abs_x > GW'(255)) ? '1 : abs_x[PW-1:0];
    mag_y = (abs_y > GW'(255)) ? '1 : abs_y[PW-1:0];
    mag_sum = {1'b0, mag_x} + {1'b0, mag_y};
    // round half to even: bump only when dropped bit set and quotient odd
    comb = mag_sum[PW:1] + PW'(mag_sum[0] & mag_sum[1]);
  end

  // ---------------- output register
  logic [RW-1:0] out_row_q;
  logic [CW-1:0] out_col_q;
  logic [GW-1:0] out_gx_q, out_gy_q;
  logic [PW-1:0] out_mx_q, out_my_q, out_comb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      out_row_q  <= s2_row_q;
      out_col_q  <= s2_col_q;
      out_gx_q   <= s2_gx_q;
      out_gy_q   <= s2_gy_q;
      out_mx_q   <= mag_x;
      out_my_q   <= mag_y;
      out_comb_q <= comb;
    end
  end

  always_comb begin
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = {3'b000, out_comb_q, out_my_q, out_mx_q, out_gy_q, out_gx_q,
                     out_col_q, out_row_q};
  end

  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_row_q != '0) && (out_col_q != '0))
    else $error("border pixel emitted");

  a_comb_rounding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      ({2'b00, out_comb_q} << 1) + 10'd1 >= {1'b0, ({1'b0, out_mx_q} + {1'b0, out_my_q})}
      && ({2'b00, out_comb_q} << 1) <= {1'b0, ({1'b0, out_mx_q} + {1'b0, out_my_q})} + 10'd1)
    else $error("combined magnitude off by more than rounding");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_pix_q))
    else $error("stage 1 item lost while stalled");

endmodule

// File: sv/sef_line_window.sv
// Line stores (older/newer row packed in one word) plus the 3x3 column window.
module sef_line_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sef_pkg::lw_ctrl_t                   ctrl_i,
  input  logic [sef_pkg::PIX_W-1:0]           pixel_i,
  output logic signed [sef_pkg::GRAD_W-1:0]   grad_x_o,
  output logic signed [sef_pkg::GRAD_W-1:0]   grad_y_o
);

  localparam int PW = sef_pkg::PIX_W;
  localparam int SW = PW + 2;

  // {older, newer}
  logic [2*PW-1:0] line_mem [sef_pkg::MAX_WIDTH];
  logic [2*PW-1:0] rd_data_q;
  logic [2*PW-1:0] fwd_data_q;
  logic            fwd_q;
  logic [2*PW-1:0] wr_data;
  logic [PW-1:0]   top, mid;
  logic [PW-1:0]   win_q [6];
  logic [SW-1:0]   x_pos, x_neg, y_pos, y_neg;

  always_comb begin
    top = fwd_q ? fwd_data_q[2*PW-1:PW] : rd_data_q[2*PW-1:PW];
    mid = fwd_q ? fwd_data_q[PW-1:0]    : rd_data_q[PW-1:0];
    wr_data = {mid, pixel_i};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= line_mem[ctrl_i.rd_col];
    end
    if (ctrl_i.wr_en) begin
      line_mem[ctrl_i.wr_col] <= wr_data;
    end
  end

  // read and write of the same column on one edge: memory returns stale data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      fwd_q <= ctrl_i.wr_en && (ctrl_i.wr_col == ctrl_i.rd_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      fwd_data_q <= wr_data;
    end
  end

  // win: 0..2 = left column (top, mid, bottom), 3..5 = middle column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (ctrl_i.wr_en) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= pixel_i;
    end
  end

  always_comb begin
    x_pos = SW'(top) + {1'b0, mid, 1'b0} + SW'(pixel_i);
    x_neg = SW'(win_q[0]) + {1'b0, win_q[1], 1'b0} + SW'(win_q[2]);
    y_pos = SW'(win_q[2]) + {1'b0, win_q[5], 1'b0} + SW'(pixel_i);
    y_neg = SW'(win_q[0]) + {1'b0, win_q[3], 1'b0} + SW'(top);
    grad_x_o = $signed({1'b0, x_pos}) - $signed({1'b0, x_neg});
    grad_y_o = $signed({1'b0, y_pos}) - $signed({1'b0, y_neg});
  end

  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(ctrl_i.wr_en && ctrl_i.rd_en))
    else $error("forward flag set without a same-edge read and write");

endmodule
